// ===== hdl/gtv_pkg.sv =====
// ----------------------------------------------------------------------------
// gtv_pkg
// Shared constants, register codes and inter-module structs for the
// grey to vertical tiled 2bpp packer.
// ----------------------------------------------------------------------------
`default_nettype none

package gtv_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int LW_W       = 9;
  localparam int RG_W       = 8;
  localparam int PIX_W      = 8;
  localparam int LANES      = 3;
  localparam int LANE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int CMP_W      = (LW_W > COL_W + 1) ? LW_W : COL_W + 1;

  localparam logic [1:0] LAST_PHASE = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_WIDTH = 2'd0,
    CFG_ROW_GROUPS = 2'd1,
    CFG_GREY_MODE  = 2'd2
  } cfg_idx_e;

  typedef logic [COL_W-1:0] col_t;

  typedef struct packed {
    logic [LANES-1:0]  wr_lane;
    logic              rd;
    col_t              addr;
    logic [LANE_W-1:0] wdata;
  } mem_req_t;

  typedef struct packed {
    logic             valid;
    logic             grey;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } issue_t;

endpackage

`default_nettype wire

// ===== hdl/gtv_line_ram.sv =====
// ----------------------------------------------------------------------------
// gtv_line_ram
// Line store: one word per column, three 2-bit lanes for rows 0..2,
// lane-masked write and registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module gtv_line_ram (
  input  wire logic                                   clk,
  input  wire gtv_pkg::mem_req_t                      req,
  output logic [gtv_pkg::LANES*gtv_pkg::LANE_W-1:0]   rd_data
);
  import gtv_pkg::*;

  logic [LANES*LANE_W-1:0] mem [MAX_WIDTH];
  logic [LANES*LANE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < LANES; k++) begin
      if (req.wr_lane[k]) begin
        mem[req.addr][k*LANE_W +: LANE_W] <= req.wdata;
      end
    end
    if (req.rd) begin
      rd_data_r <= mem[req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hdl/gtv_seq.sv =====
// ----------------------------------------------------------------------------
// gtv_seq
// Configuration registers and the column / row phase / group counters;
// issues line store accesses and result words for each accepted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module gtv_seq (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [gtv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gtv_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  wire logic                               fire,
  input  wire logic [gtv_pkg::PIX_W-1:0]          pixel,
  output gtv_pkg::mem_req_t                       mem_req,
  output gtv_pkg::issue_t                         issue
);
  import gtv_pkg::*;

  logic [LW_W-1:0]  line_width_r;
  logic [RG_W-1:0]  row_groups_r;
  logic             grey_mode_r;
  col_t             col_r, col_nxt;
  logic [1:0]       phase_r, phase_nxt;
  logic [RG_W-1:0]  grp_r, grp_nxt;

  logic [CMP_W-1:0] lw_ext;
  col_t             last_col;
  logic             end_col;
  logic             last_grp;
  logic             fin;
  logic             store_row;
  logic [RG_W-1:0]  grp_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LW_W'(128);
      row_groups_r <= RG_W'(16);
      grey_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_LINE_WIDTH: line_width_r <= cfg_wdata[LW_W-1:0];
        CFG_ROW_GROUPS: row_groups_r <= cfg_wdata[RG_W-1:0];
        CFG_GREY_MODE:  grey_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    lw_ext = CMP_W'(line_width_r);
    if (lw_ext == '0) begin
      last_col = '0;
    end else if (lw_ext > CMP_W'(MAX_WIDTH)) begin
      last_col = COL_W'(MAX_WIDTH - 1);
    end else begin
      last_col = COL_W'(lw_ext - CMP_W'(1));
    end
  end

  assign end_col   = (col_r >= last_col);
  assign last_grp  = (grp_r == RG_W'(row_groups_r - RG_W'(1)));
  assign fin       = end_col && last_grp;
  assign store_row = grey_mode_r && (phase_r != LAST_PHASE);
  assign grp_adv   = fin ? '0 : RG_W'(grp_r + RG_W'(1));

  always_comb begin
    col_nxt   = col_r;
    phase_nxt = phase_r;
    grp_nxt   = grp_r;
    if (fire) begin
      col_nxt = end_col ? '0 : COL_W'(col_r + COL_W'(1));
      if (end_col) begin
        if (store_row) begin
          phase_nxt = 2'(phase_r + 2'd1);
        end else begin
          grp_nxt = grp_adv;
          if (grey_mode_r) begin
            phase_nxt = '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      phase_r <= '0;
      grp_r   <= '0;
    end else begin
      col_r   <= col_nxt;
      phase_r <= phase_nxt;
      grp_r   <= grp_nxt;
    end
  end

  always_comb begin
    mem_req.wr_lane = '0;
    if (fire && store_row) begin
      mem_req.wr_lane[phase_r] = 1'b1;
    end
    mem_req.rd    = fire && grey_mode_r && (phase_r == LAST_PHASE);
    mem_req.addr  = col_r;
    mem_req.wdata = pixel[PIX_W-1 -: LANE_W];

    issue.valid = fire && !store_row;
    issue.grey  = grey_mode_r;
    issue.pixel = pixel;
    issue.last  = fin;
  end

endmodule

`default_nettype wire

// ===== hdl/gtv_out.sv =====
// ----------------------------------------------------------------------------
// gtv_out
// Read-data stage and output register: merges the stored rows with the
// fourth row in grey mode and holds the result word under back-pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module gtv_out (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire gtv_pkg::issue_t                        issue,
  input  wire logic [gtv_pkg::LANES*gtv_pkg::LANE_W-1:0] rd_data,
  output logic                                        in_ready,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [gtv_pkg::PIX_W-1:0]                   out_data,
  output logic                                        out_last
);
  import gtv_pkg::*;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_grey_r;
  logic [PIX_W-1:0] s1_pixel_r;
  logic             s1_last_r;
  logic             s1_adv;
  logic [PIX_W-1:0] s1_byte;

  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_data_r;
  logic             out_last_r;

  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign s1_byte  = s1_grey_r ? {s1_pixel_r[PIX_W-1 -: LANE_W], rd_data} : s1_pixel_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = issue.valid;
    end
    out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && issue.valid) begin
      s1_grey_r  <= issue.grey;
      s1_pixel_r <= issue.pixel;
      s1_last_r  <= issue.last;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= s1_byte;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/grey_to_vtiled_2bpp_packer_core.sv =====
// ----------------------------------------------------------------------------
// grey_to_vtiled_2bpp_packer_core
// Packs the top two bits of four grey rows into vertical column bytes, or
// passes mono column bytes through.
//
//   channel | ports          | word
//   --------+----------------+-------------------------------------------
//   in      | in_t*          | tdata[7:0] pixel
//   out     | out_t*         | tdata[7:0] packed_byte, tlast last
//   cfg     | cfg_*          | 0 line_width, 1 row_groups, 2 grey_mode
//
// One pixel per cycle sustained unless output stalls fill both stages; a
// result word passes the line store read, then the output register.
// Rows 0..2 of a grey group write the line store and give no word.
// Reset is synchronous; the line store needs no clearing pass.
// A stalled output holds its word while one more result waits in the
// read-data stage; in_tready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module grey_to_vtiled_2bpp_packer_core (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [gtv_pkg::PIX_W-1:0]          in_tdata,   // [7:0] pixel
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [gtv_pkg::PIX_W-1:0]               out_tdata,  // [7:0] packed_byte
  output logic                                    out_tlast,
  input  wire logic                               cfg_we,
  input  wire logic [gtv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [gtv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import gtv_pkg::*;

  logic                    fire;
  logic                    in_ready;
  mem_req_t                mem_req;
  issue_t                  issue;
  logic [LANES*LANE_W-1:0] rd_data;

  assign in_tready = in_ready;
  assign fire      = in_tvalid && in_ready;

  gtv_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .pixel     (in_tdata),
    .mem_req   (mem_req),
    .issue     (issue)
  );

  gtv_line_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  gtv_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .issue     (issue),
    .rd_data   (rd_data),
    .in_ready  (in_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/gtv_chk.sv =====
// ----------------------------------------------------------------------------
// gtv_chk
// Port-level checks for the packer core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gtv_chk (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  input  wire logic                               in_tready,
  input  wire logic                               out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic [gtv_pkg::PIX_W-1:0]          out_tdata,
  input  wire logic                               out_tlast
);
  import gtv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result word changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_rise_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result word without a pixel two cycles earlier");

endmodule

bind grey_to_vtiled_2bpp_packer_core gtv_chk u_gtv_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

`default_nettype wire

// ===== sim/tb_grey_to_vtiled_2bpp_packer_core.sv =====
// ----------------------------------------------------------------------------
// tb_grey_to_vtiled_2bpp_packer_core
// Streams grey and mono pixel words through the packer under random sender
// bursts and receiver stalls. A column model inside the bench predicts every
// packed byte and its last flag, and each output word is checked in order.
// Register settings change between runs, among them zero and oversized
// widths, zero and full row-group counts and changes part-way through a frame.
// ----------------------------------------------------------------------------
module tb_grey_to_vtiled_2bpp_packer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gtv_pkg::*;

  localparam int RUN_LIMIT  = 600000;
  localparam int RAND_ITEMS = 1650;
  localparam int BATCH_CAP  = 1100;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } col_byte_t;

  class vtile_column_model;
    logic [LW_W-1:0]   line_width;
    logic [RG_W-1:0]   row_groups;
    logic              grey_mode;
    logic [LANE_W-1:0] lane_bits [LANES][MAX_WIDTH];
    logic [7:0]        col_cnt;
    logic [1:0]        row_phase;
    logic [7:0]        group_cnt;
    col_byte_t         pending_bytes [$];
    int                mismatches;

    function new();
      line_width = 9'd128;
      row_groups = 8'd16;
      grey_mode  = 1'b0;
      col_cnt    = '0;
      row_phase  = '0;
      group_cnt  = '0;
      mismatches = 0;
      foreach (lane_bits[l, c]) lane_bits[l][c] = '0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_LINE_WIDTH: line_width = v[LW_W-1:0];
        CFG_ROW_GROUPS: row_groups = v[RG_W-1:0];
        CFG_GREY_MODE:  grey_mode  = v[0];
        default: ;
      endcase
    endfunction

    function int eff_width();
      if (line_width == '0) return 1;
      if (int'(line_width) > MAX_WIDTH) return MAX_WIDTH;
      return int'(line_width);
    endfunction

    function int words_left();
      int w;
      int cols;
      int groups;
      w      = eff_width();
      cols   = (int'(col_cnt) >= w - 1) ? 1 : w - int'(col_cnt);
      groups = int'(8'(row_groups - 8'd1 - group_cnt));
      if (!grey_mode) return cols + groups * w;
      return cols + (int'(LAST_PHASE) - int'(row_phase)) * w + groups * 4 * w;
    endfunction

    function int frame_words();
      int g;
      g = (row_groups == '0) ? 256 : int'(row_groups);
      return grey_mode ? 4 * eff_width() * g : eff_width() * g;
    endfunction

    function void take_pixel(logic [7:0] px);
      bit        end_col;
      bit        fin;
      col_byte_t e;
      end_col = int'(col_cnt) >= eff_width() - 1;
      fin     = end_col && (group_cnt == 8'(row_groups - 8'd1));
      if (grey_mode && row_phase != LAST_PHASE) begin
        lane_bits[row_phase][col_cnt] = px[7:6];
        if (end_col) begin
          col_cnt   = '0;
          row_phase = row_phase + 2'd1;
        end else begin
          col_cnt = col_cnt + 8'd1;
        end
      end else begin
        if (grey_mode) begin
          e.data = {px[7:6], lane_bits[2][col_cnt], lane_bits[1][col_cnt],
                    lane_bits[0][col_cnt]};
        end else begin
          e.data = px;
        end
        e.last = fin;
        pending_bytes.push_back(e);
        if (end_col) begin
          col_cnt   = '0;
          group_cnt = fin ? 8'd0 : group_cnt + 8'd1;
          if (grey_mode) row_phase = '0;
        end else begin
          col_cnt = col_cnt + 8'd1;
        end
      end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
      col_byte_t e;
      if (pending_bytes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word %02h last %0b with nothing pending", data, last);
        return;
      end
      e = pending_bytes.pop_front();
      if (data !== e.data || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected %02h last %0b, got %02h last %0b",
                   e.data, e.last, data, last);
      end
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [PIX_W-1:0]      out_tdata;
  logic                  out_tlast;
  logic                  cfg_we     = 1'b0;
  cfg_idx_e              cfg_index  = CFG_LINE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  vtile_column_model column_model;
  int burst_left  = 0;
  int cycles      = 0;
  int stall_span  = 0;
  int stall_style = 0;

  grey_to_vtiled_2bpp_packer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] pixel
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] packed_byte
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == RUN_LIMIT) begin
      $display("[grey_to_vtiled_2bpp_packer_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_span  <= $urandom_range(16, 160);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_style)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 3) != 0);
      2:       out_tready <= ($urandom_range(0, 1) != 0);
      default: out_tready <= ($urandom_range(0, 5) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) column_model.check_byte(out_tdata, out_tlast);
  end

  task automatic send_pixel(input logic [7:0] px);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    do @(posedge clk); while (!in_tready);
    column_model.take_pixel(px);
  endtask

  task automatic stream_random(input int n);
    repeat (n) send_pixel(8'($urandom));
  endtask

  // hold the sender until every expected word is out and the pipe is empty
  task automatic drain();
    in_tvalid <= 1'b0;
    while (column_model.pending_bytes.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    column_model.set_reg(idx, v);
  endtask

  task automatic set_format(input logic [8:0] w, input logic [7:0] g, input logic m,
                            input logic [2:0] which);
    drain();
    if (which[0]) write_reg(CFG_LINE_WIDTH, w);
    if (which[1]) write_reg(CFG_ROW_GROUPS, {1'b0, g});
    if (which[2]) write_reg(CFG_GREY_MODE, {8'd0, m});
    cfg_we <= 1'b0;
  endtask

  task automatic pick_format();
    logic [8:0] w;
    logic [7:0] g;
    case ($urandom_range(0, 9))
      0:       w = 9'd0;
      1:       w = 9'd256;
      2:       w = 9'($urandom_range(257, 511));
      3:       w = 9'd1;
      default: w = 9'($urandom_range(2, 12));
    endcase
    case ($urandom_range(0, 9))
      0:       g = 8'd0;
      1:       g = 8'd255;
      default: g = 8'($urandom_range(1, 4));
    endcase
    set_format(w, g, 1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)));
  endtask

  initial begin
    logic [7:0] mono_px [9] = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80,
                                8'h7F, 8'hFE, 8'h3C};
    logic [7:0] grey_px [8] = '{8'hC0, 8'h3F, 8'h40, 8'hBF, 8'h80, 8'h7F,
                                8'hFF, 8'h00};
    int n;
    int extra;
    int rand_sent;
    column_model = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset format, then a zero width part-way through the row
    for (int i = 0; i < 3; i++) send_pixel(mono_px[i]);
    set_format(9'd0, 8'd3, 1'b0, 3'b011);
    for (int i = 3; i < 9; i++) send_pixel(mono_px[i]);

    set_format(9'd2, 8'd1, 1'b1, 3'b111);
    foreach (grey_px[i]) send_pixel(grey_px[i]);

    // oversized width fills every line store entry
    set_format(9'($urandom_range(257, 511)), 8'd1, 1'b1, 3'b111);
    rand_sent = column_model.words_left();
    stream_random(rand_sent);

    set_format(9'd1, 8'd0, 1'b0, 3'b111);
    n = column_model.words_left();
    stream_random(n);
    rand_sent += n;

    while (rand_sent < RAND_ITEMS) begin
      pick_format();
      n = column_model.words_left();
      if (n > BATCH_CAP) begin
        n = $urandom_range(40, 300);
      end else if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, n);
      end else begin
        extra = $urandom_range(0, 2) * column_model.frame_words();
        if (n + extra <= BATCH_CAP) n += extra;
      end
      if (n > RAND_ITEMS - rand_sent) n = RAND_ITEMS - rand_sent;
      stream_random(n);
      rand_sent += n;
    end

    drain();
    repeat (10) @(posedge clk);
    if (column_model.mismatches == 0 && column_model.pending_bytes.size() == 0) begin
      $display("[grey_to_vtiled_2bpp_packer_core] OK");
    end else begin
      $display("[grey_to_vtiled_2bpp_packer_core] ERROR");
    end
    $finish;
  end

endmodule
